[hdl/ipv4_receive_filter_core_assert.svh]
// Assertion macros shared by the IPv4 receive filter modules.
`ifndef IPV4_RECEIVE_FILTER_CORE_ASSERT_SVH
`define IPV4_RECEIVE_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IPV4RF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IPV4RF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ipv4rf_pkg.sv]
// Types and constants of the IPv4 receive filter.
`timescale 1ns / 1ps

package ipv4rf_pkg;

  typedef enum logic [2:0] {
    VERDICT_TOO_SHORT = 3'd0,
    VERDICT_NOT_OURS  = 3'd1,
    VERDICT_ICMP      = 3'd2,
    VERDICT_UDP       = 3'd3,
    VERDICT_TCP       = 3'd4,
    VERDICT_OTHER     = 3'd5,
    VERDICT_BAD_LEN   = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] source_address;
    logic [5:0]  header_bytes;
    logic [15:0] payload_length;
  } out_item_t;

  // Per-frame header view, with the current byte already folded in.
  typedef struct packed {
    logic [15:0] frame_len;
    logic [15:0] total_length;
    logic [3:0]  ihl;
    logic [7:0]  protocol;
    logic [31:0] source;
    logic [31:0] destination;
  } frame_t;

  localparam logic [15:0] MIN_HEADER_LEN = 16'd20;
  localparam logic [15:0] LEN_SATURATE   = 16'hFFFF;
  localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Header byte offsets.
  localparam logic [15:0] IDX_VER_IHL = 16'd0;
  localparam logic [15:0] IDX_TLEN_HI = 16'd2;
  localparam logic [15:0] IDX_TLEN_LO = 16'd3;
  localparam logic [15:0] IDX_PROTO   = 16'd9;
  localparam logic [15:0] IDX_SRC0    = 16'd12;
  localparam logic [15:0] IDX_SRC1    = 16'd13;
  localparam logic [15:0] IDX_SRC2    = 16'd14;
  localparam logic [15:0] IDX_SRC3    = 16'd15;
  localparam logic [15:0] IDX_DST0    = 16'd16;
  localparam logic [15:0] IDX_DST1    = 16'd17;
  localparam logic [15:0] IDX_DST2    = 16'd18;
  localparam logic [15:0] IDX_DST3    = 16'd19;

endpackage

[hdl/ipv4rf_capture.sv]
// Header field capture and saturating byte count for one frame.
`timescale 1ns / 1ps
`include "ipv4_receive_filter_core_assert.svh"

module ipv4rf_capture
  import ipv4rf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     byte_en,
  input  in_item_t item,
  output frame_t   view
);

  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] tot_len_r, tot_len_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;

  // Fold the current byte into the captured fields.
  always_comb begin
    view.frame_len    = (byte_count_r == LEN_SATURATE) ? LEN_SATURATE
                                                       : byte_count_r + 16'd1;
    view.total_length = tot_len_r;
    view.ihl          = ihl_r;
    view.protocol     = proto_r;
    view.source       = src_r;
    view.destination  = dst_r;
    case (byte_count_r)
      IDX_VER_IHL: view.ihl                  = item.data_byte[3:0];
      IDX_TLEN_HI: view.total_length[15:8]   = item.data_byte;
      IDX_TLEN_LO: view.total_length[7:0]    = item.data_byte;
      IDX_PROTO:   view.protocol             = item.data_byte;
      IDX_SRC0:    view.source[31:24]        = item.data_byte;
      IDX_SRC1:    view.source[23:16]        = item.data_byte;
      IDX_SRC2:    view.source[15:8]         = item.data_byte;
      IDX_SRC3:    view.source[7:0]          = item.data_byte;
      IDX_DST0:    view.destination[31:24]   = item.data_byte;
      IDX_DST1:    view.destination[23:16]   = item.data_byte;
      IDX_DST2:    view.destination[15:8]    = item.data_byte;
      IDX_DST3:    view.destination[7:0]     = item.data_byte;
      default: begin
      end
    endcase
  end

  // Advance on every byte; clear once the last byte of the frame goes through.
  always_comb begin
    byte_count_nxt = byte_count_r;
    tot_len_nxt    = tot_len_r;
    ihl_nxt        = ihl_r;
    proto_nxt      = proto_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    if (byte_en) begin
      if (item.end_of_frame) begin
        byte_count_nxt = '0;
        tot_len_nxt    = '0;
        ihl_nxt        = '0;
        proto_nxt      = '0;
        src_nxt        = '0;
        dst_nxt        = '0;
      end else begin
        byte_count_nxt = view.frame_len;
        tot_len_nxt    = view.total_length;
        ihl_nxt        = view.ihl;
        proto_nxt      = view.protocol;
        src_nxt        = view.source;
        dst_nxt        = view.destination;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      tot_len_r    <= '0;
      ihl_r        <= '0;
      proto_r      <= '0;
      src_r        <= '0;
      dst_r        <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      tot_len_r    <= tot_len_nxt;
      ihl_r        <= ihl_nxt;
      proto_r      <= proto_nxt;
      src_r        <= src_nxt;
      dst_r        <= dst_nxt;
    end
  end

  `IPV4RF_ASSERT_NEXT(a_count_clears_after_frame, byte_en && item.end_of_frame,
    byte_count_r == '0 && dst_r == '0, "frame state not cleared after last byte")
  `IPV4RF_ASSERT_NEXT(a_count_holds_when_idle, !byte_en,
    byte_count_r == $past(byte_count_r), "byte count moved without a byte")

endmodule

[hdl/ipv4rf_verdict.sv]
// End-of-frame decision and the result register.
`timescale 1ns / 1ps
`include "ipv4_receive_filter_core_assert.svh"

module ipv4rf_verdict
  import ipv4rf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  frame_t      frame,
  input  logic [31:0] local_address,
  output logic        slot_free,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;
  logic [15:0] trim_len;
  logic [5:0]  hdr_bytes;
  logic        not_ours;

  assign hdr_bytes = {frame.ihl, 2'b00};
  assign trim_len  = (frame.total_length >= MIN_HEADER_LEN &&
                      frame.total_length < frame.frame_len) ? frame.total_length
                                                             : frame.frame_len;
  assign not_ours  = (local_address != '0) && (frame.destination != local_address) &&
                     (frame.destination != BROADCAST_ADDR);

  always_comb begin
    out_item_nxt.verdict        = VERDICT_OTHER;
    out_item_nxt.source_address = frame.source;
    out_item_nxt.header_bytes   = hdr_bytes;
    out_item_nxt.payload_length = '0;
    if (frame.frame_len < MIN_HEADER_LEN) begin
      out_item_nxt.verdict        = VERDICT_TOO_SHORT;
      out_item_nxt.source_address = '0;
      out_item_nxt.header_bytes   = '0;
    end else if (not_ours) begin
      out_item_nxt.verdict = VERDICT_NOT_OURS;
    end else if ({10'd0, hdr_bytes} > trim_len) begin
      out_item_nxt.verdict = VERDICT_BAD_LEN;
    end else begin
      out_item_nxt.payload_length = trim_len - {10'd0, hdr_bytes};
      case (frame.protocol)
        PROTO_ICMP: out_item_nxt.verdict = VERDICT_ICMP;
        PROTO_UDP:  out_item_nxt.verdict = VERDICT_UDP;
        PROTO_TCP:  out_item_nxt.verdict = VERDICT_TCP;
        default:    out_item_nxt.verdict = VERDICT_OTHER;
      endcase
    end
  end

  assign slot_free     = !out_valid_r || out_ready;
  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `IPV4RF_ASSERT_NOW(a_no_overwrite, load, slot_free,
    "result register loaded while a result is still waiting")
  `IPV4RF_ASSERT_NOW(a_short_fields_zero,
    out_valid_r && out_item_r.verdict == VERDICT_TOO_SHORT,
    out_item_r.source_address == '0 && out_item_r.header_bytes == '0 &&
    out_item_r.payload_length == '0, "too-short result carries nonzero fields")
  `IPV4RF_ASSERT_NOW(a_drop_no_payload,
    out_valid_r && (out_item_r.verdict == VERDICT_NOT_OURS ||
    out_item_r.verdict == VERDICT_BAD_LEN),
    out_item_r.payload_length == '0, "dropped packet reports a payload length")

endmodule

[hdl/ipv4_receive_filter_core.sv]
// Top level of the IPv4 receive header filter.
`timescale 1ns / 1ps

// IPv4 receive filter: takes a packet one byte per transfer on the in_
// channel, header first, with end_of_frame on its last byte, and gives one
// verdict transfer on the out_ channel per frame (too short, not ours, ICMP,
// UDP, TCP, other protocol, bad length) together with the source address,
// the header length in bytes and the payload length after padding trim.
// The block sustains one byte per clock unless a final byte waits for the
// result slot: each byte is held in the input register, then the capture
// logic and the decision logic act on it in a single pass; the last byte of
// a frame loads its verdict into the result register as it leaves the
// input register, and out_valid rises together with that load.
// Non-final bytes never wait on the
// output side; only a final byte held back by an unread result stalls
// in_ready. cfg_wr_data is written into the local address on any cycle with
// cfg_wr_en high; write it only while no frame is in flight. A local address
// of zero accepts every destination. No clearing pass after reset.

module ipv4_receive_filter_core
  import ipv4rf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_item_r;
  logic [31:0] local_addr_r, local_addr_nxt;
  logic        s1_fire;
  logic        slot_free;
  logic        result_load;
  frame_t      frame_view;

  // A non-final byte always advances; a final byte needs the result slot.
  assign s1_fire     = s1_valid_r && (!s1_item_r.end_of_frame || slot_free);
  assign result_load = s1_fire && s1_item_r.end_of_frame;
  assign in_ready    = !s1_valid_r || s1_fire;

  assign s1_valid_nxt   = (in_valid && in_ready) || (s1_valid_r && !s1_fire);
  assign local_addr_nxt = cfg_wr_en ? cfg_wr_data : local_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      local_addr_r <= '0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      local_addr_r <= local_addr_nxt;
    end
  end

  // Hold the byte until it moves on.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  ipv4rf_capture u_capture (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (s1_fire),
    .item    (s1_item_r),
    .view    (frame_view)
  );

  ipv4rf_verdict u_verdict (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (result_load),
    .frame         (frame_view),
    .local_address (local_addr_r),
    .slot_free     (slot_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item)
  );

endmodule

[tb/sv/tb_ipv4_receive_filter_core.sv]
// Self-checking testbench for the IPv4 receive header filter core.
`timescale 1ns / 1ps

module tb_ipv4_receive_filter_core;
  import ipv4rf_pkg::*;

  // Hold-off length of the receiver under pressure, in clock cycles.
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // Cycles to let pass after the last verdict before touching the register.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Approximate byte budget of one random phase.
  localparam int unsigned PHASE_BYTES = 125;
  localparam int unsigned RANDOM_PHASES = 6;
  // Percent of cycles in which a side idles.
  localparam int unsigned IDLE_PERCENT = 28;

  typedef enum logic {
    ROW_CFG,
    ROW_FRAME
  } row_kind_t;

  // One row of the directed table: a register write or a whole frame.
  typedef struct {
    row_kind_t   kind;
    logic [31:0] addr;
    int unsigned len;
    logic [3:0]  ihl;
    logic [15:0] tlen;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    bit          pinned;
    out_item_t   want;
  } stim_row_t;

  // Per-frame note: a typed-in verdict that replaces the predicted one.
  typedef struct {
    bit        pinned;
    out_item_t value;
  } frame_note_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  ipv4_receive_filter_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow copy of the filter: local address and per-frame captures.
  logic [31:0] model_local;
  logic [15:0] byte_seen;
  logic [15:0] tlen_cap;
  logic [3:0]  ihl_cap;
  logic [7:0]  proto_cap;
  logic [31:0] src_cap;
  logic [31:0] dst_cap;

  out_item_t   verdicts_due[$];
  frame_note_t frame_notes[$];
  stim_row_t   stim_rows[$];
  out_item_t   due_item;
  int unsigned failures;
  int unsigned sent_bytes;
  bit          no_gaps;
  bit          hold_off_req;

  task automatic clear_capture();
    byte_seen = '0;
    tlen_cap  = '0;
    ihl_cap   = '0;
    proto_cap = '0;
    src_cap   = '0;
    dst_cap   = '0;
  endtask

  // Fold one accepted byte into the captures; on the last byte of the frame
  // work out the verdict and queue it (or the typed-in one for this frame).
  task automatic classify_byte(input in_item_t it);
    logic [15:0] trimmed;
    logic [15:0] hdr;
    out_item_t   res;
    frame_note_t note;
    case (byte_seen)
      IDX_VER_IHL: ihl_cap = it.data_byte[3:0];
      IDX_TLEN_HI: tlen_cap[15:8] = it.data_byte;
      IDX_TLEN_LO: tlen_cap[7:0] = it.data_byte;
      IDX_PROTO:   proto_cap = it.data_byte;
      IDX_SRC0:    src_cap[31:24] = it.data_byte;
      IDX_SRC1:    src_cap[23:16] = it.data_byte;
      IDX_SRC2:    src_cap[15:8] = it.data_byte;
      IDX_SRC3:    src_cap[7:0] = it.data_byte;
      IDX_DST0:    dst_cap[31:24] = it.data_byte;
      IDX_DST1:    dst_cap[23:16] = it.data_byte;
      IDX_DST2:    dst_cap[15:8] = it.data_byte;
      IDX_DST3:    dst_cap[7:0] = it.data_byte;
      default: ;
    endcase
    if (byte_seen != LEN_SATURATE) byte_seen = byte_seen + 16'd1;
    if (it.end_of_frame) begin
      res = '0;
      res.verdict = VERDICT_TOO_SHORT;
      trimmed = byte_seen;
      hdr = {10'd0, ihl_cap, 2'b00};
      if (byte_seen >= MIN_HEADER_LEN) begin
        // Trim padding only when the total-length field is sane.
        if (tlen_cap >= MIN_HEADER_LEN && tlen_cap < byte_seen) trimmed = tlen_cap;
        res.source_address = src_cap;
        res.header_bytes   = hdr[5:0];
        if (model_local != '0 && dst_cap != model_local && dst_cap != BROADCAST_ADDR) begin
          res.verdict = VERDICT_NOT_OURS;
        end else if (hdr > trimmed) begin
          res.verdict = VERDICT_BAD_LEN;
        end else begin
          res.payload_length = trimmed - hdr;
          case (proto_cap)
            PROTO_ICMP: res.verdict = VERDICT_ICMP;
            PROTO_UDP:  res.verdict = VERDICT_UDP;
            PROTO_TCP:  res.verdict = VERDICT_TCP;
            default:    res.verdict = VERDICT_OTHER;
          endcase
        end
      end
      note.pinned = 1'b0;
      note.value  = res;
      if (frame_notes.size() != 0) note = frame_notes.pop_front();
      verdicts_due.push_back(note.pinned ? note.value : res);
      clear_capture();
    end
  endtask

  // Monitor: sample every transfer at the rising edge, before the block's
  // registers move, so the order of events within the step does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) model_local = cfg_wr_data;
      if (in_valid && in_ready) classify_byte(in_item);
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected verdict transfer: verdict %0d source %h",
                 out_item.verdict, out_item.source_address);
          failures++;
        end else begin
          due_item = verdicts_due.pop_front();
          if (out_item.verdict !== due_item.verdict) begin
            $error("verdict: expected %0d, got %0d", due_item.verdict, out_item.verdict);
            failures++;
          end
          if (out_item.source_address !== due_item.source_address) begin
            $error("source_address: expected %h, got %h",
                   due_item.source_address, out_item.source_address);
            failures++;
          end
          if (out_item.header_bytes !== due_item.header_bytes) begin
            $error("header_bytes: expected %0d, got %0d",
                   due_item.header_bytes, out_item.header_bytes);
            failures++;
          end
          if (out_item.payload_length !== due_item.payload_length) begin
            $error("payload_length: expected %0d, got %0d",
                   due_item.payload_length, out_item.payload_length);
            failures++;
          end
        end
      end
    end
  end

  // Receiver: drive out_ready at the falling edge. Idle at random, drop the
  // idling during the no-gap stretch, and on request hold off for a long
  // stretch so the block fills up and stalls its input.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        for (int unsigned k = 0; k < HOLD_OFF_CYCLES; k++) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (no_gaps) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Offer one byte; call at a falling edge. Idle at random first, then hold
  // valid and payload until the transfer, and return at the next falling edge
  // with valid still high so back-to-back bytes need no gap.
  task automatic push_byte(input logic [7:0] b, input logic eof);
    while (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: b, end_of_frame: eof};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send a whole frame: header fields at their offsets, random bytes elsewhere,
  // end_of_frame on the last byte. Register the note before the first byte.
  task automatic send_frame(input int unsigned len, input logic [3:0] ihl,
                            input logic [15:0] tlen, input logic [7:0] proto,
                            input logic [31:0] src, input logic [31:0] dst,
                            input frame_note_t note);
    logic [7:0] b;
    frame_notes.push_back(note);
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      case (i)
        IDX_VER_IHL: b = {b[7:4], ihl};
        IDX_TLEN_HI: b = tlen[15:8];
        IDX_TLEN_LO: b = tlen[7:0];
        IDX_PROTO:   b = proto;
        IDX_SRC0:    b = src[31:24];
        IDX_SRC1:    b = src[23:16];
        IDX_SRC2:    b = src[15:8];
        IDX_SRC3:    b = src[7:0];
        IDX_DST0:    b = dst[31:24];
        IDX_DST1:    b = dst[23:16];
        IDX_DST2:    b = dst[15:8];
        IDX_DST3:    b = dst[7:0];
        default: ;
      endcase
      push_byte(b, i == len - 1);
    end
    sent_bytes += len;
  endtask

  // Drop valid, wait until every verdict is in, let the pipeline settle,
  // then write the local address for one cycle. Returns at a falling edge.
  task automatic settle_and_write(input logic [31:0] addr);
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic cfg_row(input logic [31:0] addr);
    stim_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.addr = addr;
    stim_rows.push_back(r);
  endtask

  // Frame row; with pin set, the typed-in verdict, header and payload length
  // replace the prediction (source is the sent one, zero when too short).
  task automatic frame_row(input int unsigned len, input logic [3:0] ihl,
                           input logic [15:0] tlen, input logic [7:0] proto,
                           input logic [31:0] src, input logic [31:0] dst,
                           input bit pin, input verdict_t v,
                           input logic [5:0] hb, input logic [15:0] pl);
    stim_row_t r;
    r = '{kind: ROW_FRAME, default: '0};
    r.len    = len;
    r.ihl    = ihl;
    r.tlen   = tlen;
    r.proto  = proto;
    r.src    = src;
    r.dst    = dst;
    r.pinned = pin;
    r.want.verdict        = v;
    r.want.source_address = (v == VERDICT_TOO_SHORT) ? 32'd0 : src;
    r.want.header_bytes   = hb;
    r.want.payload_length = pl;
    stim_rows.push_back(r);
  endtask

  // Main sequence: reset, directed table, random phases, drain, report.
  initial begin
    frame_note_t plain;
    logic [31:0] phase_addr;
    logic [31:0] dst_r;
    logic [15:0] tlen_r;
    logic [7:0]  proto_r;
    logic [3:0]  ihl_r;
    int unsigned len_r;
    int unsigned tl_r;
    int unsigned phase_start;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    failures    = 0;
    sent_bytes  = 0;
    no_gaps     = 1'b0;
    hold_off_req = 1'b0;
    model_local = '0;
    clear_capture();
    plain.pinned = 1'b0;
    plain.value  = '0;

    // Directed table. Local address starts at zero: every destination passes.
    frame_row(1, 4'd5, 16'd1, PROTO_ICMP, 32'h0A00_0001, 32'h0A00_0002,
              1, VERDICT_TOO_SHORT, 6'd0, 16'd0);
    frame_row(19, 4'd5, 16'd19, PROTO_UDP, 32'h0A00_0001, 32'h0A00_0002,
              1, VERDICT_TOO_SHORT, 6'd0, 16'd0);
    frame_row(20, 4'd5, 16'd20, PROTO_ICMP, 32'h0A00_0001, 32'h1234_5678,
              1, VERDICT_ICMP, 6'd20, 16'd0);
    frame_row(40, 4'd5, 16'd40, PROTO_UDP, 32'hC0A8_0107, 32'h0000_0000,
              1, VERDICT_UDP, 6'd20, 16'd20);
    frame_row(60, 4'd15, 16'd60, PROTO_TCP, 32'h8000_0001, 32'hFFFF_FFFF,
              1, VERDICT_TCP, 6'd60, 16'd0);
    frame_row(30, 4'd5, 16'd30, 8'hFF, 32'hFFFF_FFFF, 32'h0101_0101,
              1, VERDICT_OTHER, 6'd20, 16'd10);
    // Padding trim, insane total-length fields, field equal to frame length.
    frame_row(64, 4'd5, 16'd46, PROTO_TCP, 32'h0102_0304, 32'h0506_0708,
              0, VERDICT_TCP, 6'd0, 16'd0);
    frame_row(50, 4'd5, 16'd19, PROTO_UDP, 32'h0A0B_0C0D, 32'h0E0F_1011,
              0, VERDICT_UDP, 6'd0, 16'd0);
    frame_row(30, 4'd5, 16'hFFFF, PROTO_ICMP, 32'h7F00_0001, 32'h7F00_0002,
              0, VERDICT_ICMP, 6'd0, 16'd0);
    frame_row(44, 4'd6, 16'd44, 8'h00, 32'h0000_0000, 32'hDEAD_BEEF,
              0, VERDICT_OTHER, 6'd0, 16'd0);
    // Header longer than the packet, directly and through the trim.
    frame_row(40, 4'd15, 16'd40, PROTO_TCP, 32'h0A00_00FE, 32'h0A00_00FF,
              1, VERDICT_BAD_LEN, 6'd60, 16'd0);
    frame_row(100, 4'd8, 16'd24, PROTO_UDP, 32'h1111_2222, 32'h3333_4444,
              0, VERDICT_BAD_LEN, 6'd0, 16'd0);
    // IHL of zero is taken as it is.
    frame_row(25, 4'd0, 16'd25, PROTO_ICMP, 32'h5555_AAAA, 32'hAAAA_5555,
              0, VERDICT_ICMP, 6'd0, 16'd0);
    cfg_row(32'hC0A8_0001);
    frame_row(20, 4'd5, 16'd20, PROTO_ICMP, 32'h0A00_0001, 32'hC0A8_0001,
              0, VERDICT_ICMP, 6'd0, 16'd0);
    frame_row(36, 4'd5, 16'd36, PROTO_UDP, 32'h0A00_0002, BROADCAST_ADDR,
              0, VERDICT_UDP, 6'd0, 16'd0);
    frame_row(28, 4'd5, 16'd28, PROTO_TCP, 32'h0A00_0003, 32'hC0A8_0002,
              1, VERDICT_NOT_OURS, 6'd20, 16'd0);
    // Not ours wins over a bad header length.
    frame_row(30, 4'd15, 16'd30, PROTO_UDP, 32'h0A00_0004, 32'h0000_0000,
              1, VERDICT_NOT_OURS, 6'd60, 16'd0);
    frame_row(10, 4'd5, 16'd10, PROTO_UDP, 32'h0A00_0005, 32'hC0A8_0001,
              1, VERDICT_TOO_SHORT, 6'd0, 16'd0);
    cfg_row(32'hFFFF_FFFF);
    frame_row(24, 4'd5, 16'd24, PROTO_UDP, 32'h0A00_0006, BROADCAST_ADDR,
              0, VERDICT_UDP, 6'd0, 16'd0);
    frame_row(24, 4'd5, 16'd24, PROTO_TCP, 32'h0A00_0007, 32'hFFFF_FFFE,
              1, VERDICT_NOT_OURS, 6'd20, 16'd0);
    cfg_row(32'h0000_0001);
    frame_row(32, 4'd7, 16'd32, PROTO_TCP, 32'h0A00_0008, 32'h0000_0001,
              0, VERDICT_TCP, 6'd0, 16'd0);

    // Hold reset, then release it at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        settle_and_write(stim_rows[i].addr);
      end else begin
        plain.pinned = stim_rows[i].pinned;
        plain.value  = stim_rows[i].want;
        send_frame(stim_rows[i].len, stim_rows[i].ihl, stim_rows[i].tlen,
                   stim_rows[i].proto, stim_rows[i].src, stim_rows[i].dst, plain);
      end
    end
    plain.pinned = 1'b0;
    plain.value  = '0;

    // Random phases, each under its own local address, extremes among them.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        1:       phase_addr = 32'h0000_0000;
        2:       phase_addr = 32'hFFFF_FFFF;
        default: phase_addr = $urandom;
      endcase
      settle_and_write(phase_addr);
      no_gaps = (phase == 4);
      if (phase == 2) begin
        // Hold the receiver off and keep offering short frames: the block
        // fills up and must stall its input until the receiver comes back.
        hold_off_req = 1'b1;
        repeat (12) send_frame(20, 4'd5, 16'd20, PROTO_UDP, $urandom, BROADCAST_ADDR, plain);
      end
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < PHASE_BYTES) begin
        case ($urandom_range(3))
          0:       dst_r = phase_addr;
          1:       dst_r = BROADCAST_ADDR;
          2:       dst_r = $urandom;
          default: dst_r = phase_addr ^ (32'd1 << $urandom_range(31));
        endcase
        case ($urandom_range(3))
          0:       proto_r = PROTO_ICMP;
          1:       proto_r = PROTO_UDP;
          2:       proto_r = PROTO_TCP;
          default: proto_r = 8'($urandom_range(255));
        endcase
        if ($urandom_range(99) < 80) begin
          // Well-formed packet with random content and optional padding.
          ihl_r  = ($urandom_range(99) < 60) ? 4'd5 : 4'($urandom_range(15, 5));
          tl_r   = ihl_r * 4 + $urandom_range(30);
          len_r  = tl_r + (($urandom_range(1) == 0) ? 0 : $urandom_range(12, 1));
          tlen_r = ($urandom_range(99) < 10) ? 16'($urandom_range(65535)) : 16'(tl_r);
        end else begin
          // Noise: any length, any header fields.
          ihl_r  = 4'($urandom_range(15));
          len_r  = $urandom_range(60, 1);
          tlen_r = ($urandom_range(1) == 0) ? 16'($urandom_range(100))
                                            : 16'($urandom_range(65535));
        end
        send_frame(len_r, ihl_r, tlen_r, proto_r, $urandom, dst_r, plain);
      end
    end
    no_gaps = 1'b0;

    // Drain: drop valid, wait for the last verdict, then let the block settle.
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 3) @(posedge clk);
    if (failures == 0 && verdicts_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
